// File: rtl/assert_macros.svh
// assertion macros for the rtl files, included by cvs_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under reset
`define AST_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication under reset
`define AST_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/cvs_pkg.sv
// types and constants of the closest view selector
`default_nettype none
package cvs_pkg;

    localparam int RED_LIMIT = 32767;
    localparam int SQ_STEPS  = 32;
    localparam int DV_STEPS  = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COS   = 2'd1;

    localparam logic [15:0] SCALE_RESET = 16'd1024;
    localparam logic signed [15:0] COS_RESET      = 16'sd31000;
    localparam logic signed [15:0] COS_MINUS_ONE  = 16'sh8000;
    localparam logic signed [15:0] COS_MINUS_HALF = 16'shC000;
    localparam logic signed [15:0] COS_MAX        = 16'sh7FFF;

    typedef enum logic [4:0] {
        S_IDLE, S_NEXT, S_RD, S_LD, S_MAGS, S_SRCH, S_RED, S_NA, S_STA, S_NB,
        S_STB, S_MN, S_TEST, S_ZCHK, S_AB, S_SQI, S_SQ, S_DOT, S_DVI, S_DV,
        S_UPD, S_ADV, S_FIN
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_ACCEPT, OP_LOAD, OP_MAGS, OP_SRCH, OP_RED, OP_MAC, OP_STA,
        OP_STB, OP_SQI, OP_SQ, OP_DVI, OP_DV, OP_UPD, OP_FIN
    } t_op;

    typedef enum logic [2:0] {
        M_UU, M_VV, M_UV, M_AB, M_MN
    } t_msel;

    typedef struct packed {
        t_op        op;
        t_msel      msel;
        logic [1:0] lane;
        logic       clr;
        logic       phase;
        logic       pend;
    } t_ctrl;

    typedef struct packed {
        logic srch_done;
        logic ratio_ok;
        logic ab_zero;
        logic pend_try;
    } t_stat;

endpackage
`default_nettype wire

// File: rtl/cvs_ram.sv
// generic single-port-write ram with registered read
`default_nettype none
module cvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                     i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// File: rtl/cvs_ctrl.sv
// sequencer of the closest view selector
`default_nettype none
`include "assert_macros.svh"
module cvs_ctrl #(
    parameter int MAX_VIEWS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic                              i_cmd,
    input  wire cvs_pkg::t_stat                    i_stat,
    input  wire logic [$clog2(MAX_VIEWS+1)-1:0]    i_count,
    output logic                                   o_busy,
    output cvs_pkg::t_ctrl                         o_ctrl,
    output logic [$clog2(MAX_VIEWS+1)-1:0]         o_idx
);
    localparam int CW = $clog2(MAX_VIEWS + 1);

    cvs_pkg::t_state r_state, n_state;
    logic [5:0]      r_step;
    logic [CW-1:0]   r_idx;
    logic            r_phase;
    logic            r_pend;
    logic            accept;

    assign accept = i_start && (r_state == cvs_pkg::S_IDLE);
    assign o_busy = (r_state != cvs_pkg::S_IDLE);
    assign o_idx  = r_idx;

    always_comb begin
        n_state = r_state;
        case (r_state)
            cvs_pkg::S_IDLE: if (accept && i_cmd) n_state = cvs_pkg::S_NEXT;
            cvs_pkg::S_NEXT: begin
                if (!r_pend && (r_idx < i_count)) n_state = cvs_pkg::S_RD;
                else if (!r_pend && i_stat.pend_try) n_state = cvs_pkg::S_LD;
                else n_state = cvs_pkg::S_FIN;
            end
            cvs_pkg::S_RD:   n_state = cvs_pkg::S_LD;
            cvs_pkg::S_LD:   n_state = cvs_pkg::S_MAGS;
            cvs_pkg::S_MAGS: n_state = cvs_pkg::S_SRCH;
            cvs_pkg::S_SRCH: if (i_stat.srch_done) n_state = cvs_pkg::S_RED;
            cvs_pkg::S_RED:  n_state = cvs_pkg::S_NA;
            cvs_pkg::S_NA:   if (r_step == 6'd2) n_state = cvs_pkg::S_STA;
            cvs_pkg::S_STA:  n_state = cvs_pkg::S_NB;
            cvs_pkg::S_NB:   if (r_step == 6'd2) n_state = cvs_pkg::S_STB;
            cvs_pkg::S_STB:  n_state = r_phase ? cvs_pkg::S_ZCHK : cvs_pkg::S_MN;
            cvs_pkg::S_MN:   n_state = cvs_pkg::S_TEST;
            cvs_pkg::S_TEST: n_state = i_stat.ratio_ok ? cvs_pkg::S_RED : cvs_pkg::S_ADV;
            cvs_pkg::S_ZCHK: n_state = i_stat.ab_zero ? cvs_pkg::S_ADV : cvs_pkg::S_AB;
            cvs_pkg::S_AB:   n_state = cvs_pkg::S_SQI;
            cvs_pkg::S_SQI:  n_state = cvs_pkg::S_SQ;
            cvs_pkg::S_SQ: begin
                if (r_step == 6'(cvs_pkg::SQ_STEPS - 1)) n_state = cvs_pkg::S_DOT;
            end
            cvs_pkg::S_DOT:  if (r_step == 6'd2) n_state = cvs_pkg::S_DVI;
            cvs_pkg::S_DVI:  n_state = cvs_pkg::S_DV;
            cvs_pkg::S_DV: begin
                if (r_step == 6'(cvs_pkg::DV_STEPS - 1)) n_state = cvs_pkg::S_UPD;
            end
            cvs_pkg::S_UPD:  n_state = cvs_pkg::S_ADV;
            cvs_pkg::S_ADV:  n_state = cvs_pkg::S_NEXT;
            cvs_pkg::S_FIN:  n_state = cvs_pkg::S_IDLE;
            default:         n_state = cvs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl       = '0;
        o_ctrl.op    = cvs_pkg::OP_NONE;
        o_ctrl.msel  = cvs_pkg::M_UU;
        o_ctrl.lane  = r_step[1:0];
        o_ctrl.clr   = (r_step == 6'd0);
        o_ctrl.phase = r_phase;
        o_ctrl.pend  = r_pend;
        case (r_state)
            cvs_pkg::S_IDLE: if (accept) o_ctrl.op = cvs_pkg::OP_ACCEPT;
            cvs_pkg::S_LD:   o_ctrl.op = cvs_pkg::OP_LOAD;
            cvs_pkg::S_MAGS: o_ctrl.op = cvs_pkg::OP_MAGS;
            cvs_pkg::S_SRCH: o_ctrl.op = cvs_pkg::OP_SRCH;
            cvs_pkg::S_RED:  o_ctrl.op = cvs_pkg::OP_RED;
            cvs_pkg::S_NA: begin
                o_ctrl.op   = cvs_pkg::OP_MAC;
                o_ctrl.msel = cvs_pkg::M_UU;
            end
            cvs_pkg::S_STA:  o_ctrl.op = cvs_pkg::OP_STA;
            cvs_pkg::S_NB: begin
                o_ctrl.op   = cvs_pkg::OP_MAC;
                o_ctrl.msel = cvs_pkg::M_VV;
            end
            cvs_pkg::S_STB:  o_ctrl.op = cvs_pkg::OP_STB;
            cvs_pkg::S_MN: begin
                o_ctrl.op   = cvs_pkg::OP_MAC;
                o_ctrl.msel = cvs_pkg::M_MN;
            end
            cvs_pkg::S_AB: begin
                o_ctrl.op   = cvs_pkg::OP_MAC;
                o_ctrl.msel = cvs_pkg::M_AB;
            end
            cvs_pkg::S_SQI:  o_ctrl.op = cvs_pkg::OP_SQI;
            cvs_pkg::S_SQ:   o_ctrl.op = cvs_pkg::OP_SQ;
            cvs_pkg::S_DOT: begin
                o_ctrl.op   = cvs_pkg::OP_MAC;
                o_ctrl.msel = cvs_pkg::M_UV;
            end
            cvs_pkg::S_DVI:  o_ctrl.op = cvs_pkg::OP_DVI;
            cvs_pkg::S_DV:   o_ctrl.op = cvs_pkg::OP_DV;
            cvs_pkg::S_UPD:  o_ctrl.op = cvs_pkg::OP_UPD;
            cvs_pkg::S_FIN:  o_ctrl.op = cvs_pkg::OP_FIN;
            default:         o_ctrl.op = cvs_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cvs_pkg::S_IDLE;
            r_step  <= '0;
            r_idx   <= '0;
            r_phase <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= (n_state != r_state) ? 6'd0 : r_step + 6'd1;
            if (accept) begin
                r_idx  <= '0;
                r_pend <= 1'b0;
            end
            if (r_state == cvs_pkg::S_NEXT && n_state == cvs_pkg::S_LD) r_pend <= 1'b1;
            if (r_state == cvs_pkg::S_ADV && !r_pend) r_idx <= r_idx + CW'(1);
            if (r_state == cvs_pkg::S_MAGS) r_phase <= 1'b0;
            if (r_state == cvs_pkg::S_TEST) r_phase <= 1'b1;
        end
    end

    `AST_NXT(a_query_busy, i_clk, i_rst_n, accept && i_cmd, o_busy)
    `AST_NXT(a_obs_idle, i_clk, i_rst_n, accept && !i_cmd, !o_busy)
    `AST_IMP(a_sq_bound, i_clk, i_rst_n, r_state == cvs_pkg::S_SQ, r_step < 6'(cvs_pkg::SQ_STEPS))
    `AST_IMP(a_rd_stored, i_clk, i_rst_n, r_state == cvs_pkg::S_RD, !r_pend && (r_idx < i_count))
endmodule
`default_nettype wire

// File: rtl/cvs_dpath.sv
// datapath: view store, vector math, square root, divide and selection
`default_nettype none
module cvs_dpath #(
    parameter int MAX_VIEWS  = 16,
    parameter int COORD_BITS = 32
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire cvs_pkg::t_ctrl                         i_ctrl,
    input  wire logic [$clog2(MAX_VIEWS+1)-1:0]         i_idx,
    output cvs_pkg::t_stat                              o_stat,
    output logic [$clog2(MAX_VIEWS+1)-1:0]              o_count,
    input  wire logic                                   i_cfg_we,
    input  wire logic [cvs_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  wire logic [15:0]                            i_cfg_wdata,
    input  wire logic                                   i_cmd,
    input  wire logic                                   i_ev_updated,
    input  wire logic                                   i_ev_predicted,
    input  wire logic                                   i_ev_measured,
    input  wire logic                                   i_ev_matched,
    input  wire logic                                   i_patch_ok,
    input  wire logic signed [COORD_BITS-1:0]           i_sensor_x,
    input  wire logic signed [COORD_BITS-1:0]           i_sensor_y,
    input  wire logic signed [COORD_BITS-1:0]           i_sensor_z,
    input  wire logic signed [COORD_BITS-1:0]           i_landmark_x,
    input  wire logic signed [COORD_BITS-1:0]           i_landmark_y,
    input  wire logic signed [COORD_BITS-1:0]           i_landmark_z,
    output logic                                        o_done,
    output logic                                        o_obs_accepted,
    output logic                                        o_view_found,
    output logic [4:0]                                  o_view_index,
    output logic                                        o_prediction_valid,
    output logic                                        o_new_view_stored,
    output logic                                        o_store_full,
    output logic [4:0]                                  o_view_count
);
    localparam int CB = COORD_BITS;
    localparam int VW = CB + 1;
    localparam int CW = $clog2(MAX_VIEWS + 1);
    localparam int AW = (MAX_VIEWS > 1) ? $clog2(MAX_VIEWS) : 1;
    localparam int KW = $clog2(VW + 1);

    function automatic logic [VW-1:0] f_mag(input logic signed [VW-1:0] v);
        return v[VW-1] ? VW'(-v) : VW'(v);
    endfunction

    function automatic logic [VW-1:0] f_max3(input logic signed [VW-1:0] a,
                                             input logic signed [VW-1:0] b,
                                             input logic signed [VW-1:0] c);
        logic [VW-1:0] m;
        m = f_mag(a);
        if (f_mag(b) > m) m = f_mag(b);
        if (f_mag(c) > m) m = f_mag(c);
        return m;
    endfunction

    function automatic logic signed [15:0] f_red(input logic signed [VW-1:0] v,
                                                 input logic [KW-1:0] k);
        logic [VW-1:0] m;
        logic [15:0]   q;
        m = f_mag(v) >> k;
        q = {1'b0, m[14:0]};
        return v[VW-1] ? -q : q;
    endfunction

    logic [15:0]            r_sss;
    logic signed [15:0]     r_cas;
    logic [CW-1:0]          r_count;
    logic                   r_pv, r_lmf;
    logic signed [CB-1:0]   r_px, r_py, r_pz;
    logic signed [CB-1:0]   r_lmk [3];
    logic signed [VW-1:0]   r_cur [3];
    logic signed [VW-1:0]   r_sv  [3];
    logic [VW-1:0]          r_mu, r_mv, r_mc;
    logic [KW-1:0]          r_ku, r_kv, r_kc;
    logic signed [15:0]     r_ru [3];
    logic signed [15:0]     r_rv [3];
    logic signed [65:0]     r_acc;
    logic [31:0]            r_a, r_b;
    logic [63:0]            r_sqx, r_sqr, r_sqb;
    logic [31:0]            r_rem;
    logic [16:0]            r_dn, r_q;
    logic                   r_neg;
    logic signed [15:0]     r_best;
    logic                   r_have, r_isp;
    logic [CW-1:0]          r_sel;
    logic                   r_done, r_obs_acc, r_found, r_pvalid, r_stored, r_full;
    logic [4:0]             r_vidx, r_vcnt;

    logic [3*CB-1:0]        ram_rdata;
    logic                   ram_we;
    logic signed [CB-1:0]   src [3];
    logic signed [CB-1:0]   sen [3];
    logic signed [CB-1:0]   lin [3];
    logic signed [32:0]     op_a, op_b;
    logic signed [65:0]     prod;
    logic [31:0]            mx, mn, root;
    logic [63:0]            sq_t;
    logic [32:0]            adot, rem2;
    logic signed [15:0]     cosv;
    logic                   room, have_f;
    logic [CW-1:0]          cnt_f, sel_f;

    assign sen[0] = CB'(i_sensor_x);
    assign sen[1] = CB'(i_sensor_y);
    assign sen[2] = CB'(i_sensor_z);
    assign lin[0] = CB'(i_landmark_x);
    assign lin[1] = CB'(i_landmark_y);
    assign lin[2] = CB'(i_landmark_z);

    assign room   = (r_count < CW'(MAX_VIEWS));
    assign ram_we = (i_ctrl.op == cvs_pkg::OP_FIN) && r_isp && room;

    cvs_ram #(
        .WIDTH (3 * CB),
        .DEPTH (MAX_VIEWS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({r_px, r_py, r_pz}),
        .i_raddr (i_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (i_ctrl.pend) begin
            src[0] = r_px;
            src[1] = r_py;
            src[2] = r_pz;
        end else begin
            src[0] = ram_rdata[3*CB-1:2*CB];
            src[1] = ram_rdata[2*CB-1:CB];
            src[2] = ram_rdata[CB-1:0];
        end
    end

    // multiply-accumulate operand select
    always_comb begin
        mx = (r_a > r_b) ? r_a : r_b;
        mn = (r_a > r_b) ? r_b : r_a;
        op_a = '0;
        op_b = '0;
        case (i_ctrl.msel)
            cvs_pkg::M_UU, cvs_pkg::M_VV, cvs_pkg::M_UV: begin
                case (i_ctrl.lane)
                    2'd0: begin
                        op_a = 33'((i_ctrl.msel == cvs_pkg::M_VV) ? r_rv[0] : r_ru[0]);
                        op_b = 33'((i_ctrl.msel == cvs_pkg::M_UU) ? r_ru[0] : r_rv[0]);
                    end
                    2'd1: begin
                        op_a = 33'((i_ctrl.msel == cvs_pkg::M_VV) ? r_rv[1] : r_ru[1]);
                        op_b = 33'((i_ctrl.msel == cvs_pkg::M_UU) ? r_ru[1] : r_rv[1]);
                    end
                    default: begin
                        op_a = 33'((i_ctrl.msel == cvs_pkg::M_VV) ? r_rv[2] : r_ru[2]);
                        op_b = 33'((i_ctrl.msel == cvs_pkg::M_UU) ? r_ru[2] : r_rv[2]);
                    end
                endcase
            end
            cvs_pkg::M_AB: begin
                op_a = $signed({1'b0, r_a});
                op_b = $signed({1'b0, r_b});
            end
            cvs_pkg::M_MN: begin
                op_a = $signed({1'b0, mn});
                op_b = $signed({17'd0, r_sss});
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        prod = op_a * op_b;
    end

    assign root = r_sqr[31:0];
    assign sq_t = r_sqr + r_sqb;
    assign adot = r_acc[65] ? 33'(-r_acc) : 33'(r_acc);
    assign rem2 = {r_rem, r_dn[16]};

    always_comb begin
        if (r_neg) begin
            cosv = (r_q >= 17'd32768) ? cvs_pkg::COS_MINUS_ONE : $signed(-{1'b0, r_q[14:0]});
        end else begin
            cosv = (r_q >= 17'd32767) ? cvs_pkg::COS_MAX : $signed({1'b0, r_q[14:0]});
        end
    end

    assign have_f = r_have && !(r_best < cvs_pkg::COS_MINUS_HALF);
    assign cnt_f  = (r_isp && room) ? r_count + CW'(1) : r_count;
    assign sel_f  = r_isp ? (room ? r_count : CW'(MAX_VIEWS)) : r_sel;

    assign o_stat.srch_done = (r_mu <= VW'(cvs_pkg::RED_LIMIT)) &&
                              (r_mv <= VW'(cvs_pkg::RED_LIMIT)) &&
                              (r_mc <= VW'(cvs_pkg::RED_LIMIT));
    assign o_stat.ratio_ok  = ({26'd0, mx, 8'd0} < $unsigned(r_acc));
    assign o_stat.ab_zero   = (r_a == 32'd0) || (r_b == 32'd0);
    assign o_stat.pend_try  = (!r_have || ((r_best < r_cas) && r_lmf)) && r_pv;
    assign o_count          = r_count;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sss   <= cvs_pkg::SCALE_RESET;
            r_cas   <= cvs_pkg::COS_RESET;
            r_count <= '0;
            r_pv    <= 1'b0;
            r_lmf   <= 1'b0;
            r_px    <= '0;
            r_py    <= '0;
            r_pz    <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_idx == cvs_pkg::REG_SCALE) r_sss <= i_cfg_wdata;
                if (i_cfg_idx == cvs_pkg::REG_COS) r_cas <= $signed(i_cfg_wdata);
            end
            if (i_ctrl.op == cvs_pkg::OP_ACCEPT && !i_cmd) begin
                r_done <= 1'b1;
                if (i_ev_updated) begin
                    if (i_patch_ok) begin
                        r_px <= sen[0];
                        r_py <= sen[1];
                        r_pz <= sen[2];
                        r_pv <= 1'b1;
                    end
                    r_lmf <= 1'b0;
                end else if (i_ev_predicted && i_ev_measured && !i_ev_matched) begin
                    r_lmf <= 1'b1;
                end
            end
            if (i_ctrl.op == cvs_pkg::OP_FIN) begin
                r_done <= 1'b1;
                if (r_isp && room) begin
                    r_count <= r_count + CW'(1);
                    r_pv    <= 1'b0;
                    r_px    <= '0;
                    r_py    <= '0;
                    r_pz    <= '0;
                end
            end
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            cvs_pkg::OP_ACCEPT: begin
                r_obs_acc <= !i_cmd && i_ev_updated && i_patch_ok;
                r_found   <= 1'b0;
                r_vidx    <= '0;
                r_pvalid  <= 1'b0;
                r_stored  <= 1'b0;
                r_full    <= 1'b0;
                r_vcnt    <= 5'(r_count);
                for (int i = 0; i < 3; i++) begin
                    r_lmk[i] <= lin[i];
                    r_cur[i] <= VW'(lin[i]) - VW'(sen[i]);
                end
                r_best <= cvs_pkg::COS_MINUS_ONE;
                r_have <= 1'b0;
                r_sel  <= '0;
                r_isp  <= 1'b0;
            end
            cvs_pkg::OP_LOAD: begin
                for (int i = 0; i < 3; i++) begin
                    r_sv[i] <= VW'(r_lmk[i]) - VW'(src[i]);
                end
            end
            cvs_pkg::OP_MAGS: begin
                r_mu <= f_max3(r_cur[0], r_cur[1], r_cur[2]);
                r_mv <= f_max3(r_sv[0], r_sv[1], r_sv[2]);
                r_mc <= (f_max3(r_cur[0], r_cur[1], r_cur[2]) >
                         f_max3(r_sv[0], r_sv[1], r_sv[2])) ?
                        f_max3(r_cur[0], r_cur[1], r_cur[2]) :
                        f_max3(r_sv[0], r_sv[1], r_sv[2]);
                r_ku <= '0;
                r_kv <= '0;
                r_kc <= '0;
            end
            cvs_pkg::OP_SRCH: begin
                if (r_mu > VW'(cvs_pkg::RED_LIMIT)) begin
                    r_mu <= r_mu >> 1;
                    r_ku <= r_ku + KW'(1);
                end
                if (r_mv > VW'(cvs_pkg::RED_LIMIT)) begin
                    r_mv <= r_mv >> 1;
                    r_kv <= r_kv + KW'(1);
                end
                if (r_mc > VW'(cvs_pkg::RED_LIMIT)) begin
                    r_mc <= r_mc >> 1;
                    r_kc <= r_kc + KW'(1);
                end
            end
            cvs_pkg::OP_RED: begin
                for (int i = 0; i < 3; i++) begin
                    r_ru[i] <= f_red(r_cur[i], i_ctrl.phase ? r_ku : r_kc);
                    r_rv[i] <= f_red(r_sv[i], i_ctrl.phase ? r_kv : r_kc);
                end
            end
            cvs_pkg::OP_MAC: begin
                r_acc <= (i_ctrl.clr ? 66'sd0 : r_acc) + prod;
            end
            cvs_pkg::OP_STA: r_a <= r_acc[31:0];
            cvs_pkg::OP_STB: r_b <= r_acc[31:0];
            cvs_pkg::OP_SQI: begin
                r_sqx <= r_acc[63:0];
                r_sqr <= '0;
                r_sqb <= 64'h4000_0000_0000_0000;
            end
            cvs_pkg::OP_SQ: begin
                if (r_sqx >= sq_t) begin
                    r_sqx <= r_sqx - sq_t;
                    r_sqr <= (r_sqr >> 1) + r_sqb;
                end else begin
                    r_sqr <= r_sqr >> 1;
                end
                r_sqb <= r_sqb >> 2;
            end
            cvs_pkg::OP_DVI: begin
                r_neg <= r_acc[65];
                r_rem <= 32'(adot[32:2]);
                r_dn  <= {adot[1:0], 15'd0};
                r_q   <= '0;
            end
            cvs_pkg::OP_DV: begin
                if (rem2 >= {1'b0, root}) begin
                    r_rem <= 32'(rem2 - {1'b0, root});
                    r_q   <= {r_q[15:0], 1'b1};
                end else begin
                    r_rem <= rem2[31:0];
                    r_q   <= {r_q[15:0], 1'b0};
                end
                r_dn <= {r_dn[15:0], 1'b0};
            end
            cvs_pkg::OP_UPD: begin
                if (cosv > r_best) begin
                    r_best <= cosv;
                    r_have <= 1'b1;
                    if (i_ctrl.pend) r_isp <= 1'b1;
                    else r_sel <= i_idx;
                end
            end
            cvs_pkg::OP_FIN: begin
                r_obs_acc <= 1'b0;
                r_found   <= have_f;
                r_vidx    <= have_f ? 5'(sel_f) : 5'd0;
                r_pvalid  <= have_f && (r_best >= r_cas);
                r_stored  <= r_isp && room;
                r_full    <= r_isp && !room;
                r_vcnt    <= 5'(cnt_f);
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    assign o_done             = r_done;
    assign o_obs_accepted     = r_obs_acc;
    assign o_view_found       = r_found;
    assign o_view_index       = r_vidx;
    assign o_prediction_valid = r_pvalid;
    assign o_new_view_stored  = r_stored;
    assign o_store_full       = r_full;
    assign o_view_count       = r_vcnt;
endmodule
`default_nettype wire

// File: rtl/closest_view_selector_unit.sv
// top level of the closest view selector
// observation item: result on o_done in the cycle after acceptance, busy stays low
// query item: result on o_done after each stored view, and the pending view when it is tried,
// has gone through the shift search and, where its tests pass, the 32-step root and 17-step divide
// one item at a time; the next start is taken as the result is strobed, no stall
// synchronous active-low reset clears control, counts and the pending view and sets config defaults;
// result registers and the view store are undefined until written, and the store needs no clearing pass
`default_nettype none
module closest_view_selector_unit #(
    parameter int MAX_VIEWS  = 16,
    parameter int COORD_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_cfg_we,
    input  wire logic [cvs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [15:0]                   i_cfg_wdata,
    input  wire logic                          i_cmd,
    input  wire logic                          i_ev_updated,
    input  wire logic                          i_ev_predicted,
    input  wire logic                          i_ev_measured,
    input  wire logic                          i_ev_matched,
    input  wire logic                          i_patch_ok,
    input  wire logic signed [COORD_BITS-1:0]  i_sensor_x,
    input  wire logic signed [COORD_BITS-1:0]  i_sensor_y,
    input  wire logic signed [COORD_BITS-1:0]  i_sensor_z,
    input  wire logic signed [COORD_BITS-1:0]  i_landmark_x,
    input  wire logic signed [COORD_BITS-1:0]  i_landmark_y,
    input  wire logic signed [COORD_BITS-1:0]  i_landmark_z,
    output logic                               o_done,
    output logic                               o_obs_accepted,
    output logic                               o_view_found,
    output logic [4:0]                         o_view_index,
    output logic                               o_prediction_valid,
    output logic                               o_new_view_stored,
    output logic                               o_store_full,
    output logic [4:0]                         o_view_count
);
    localparam int CW = $clog2(MAX_VIEWS + 1);

    cvs_pkg::t_ctrl ctrl;
    cvs_pkg::t_stat stat;
    logic [CW-1:0]  idx;
    logic [CW-1:0]  count;

    cvs_ctrl #(
        .MAX_VIEWS (MAX_VIEWS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_cmd),
        .i_stat  (stat),
        .i_count (count),
        .o_busy  (busy),
        .o_ctrl  (ctrl),
        .o_idx   (idx)
    );

    cvs_dpath #(
        .MAX_VIEWS  (MAX_VIEWS),
        .COORD_BITS (COORD_BITS)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctrl             (ctrl),
        .i_idx              (idx),
        .o_stat             (stat),
        .o_count            (count),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_cmd              (i_cmd),
        .i_ev_updated       (i_ev_updated),
        .i_ev_predicted     (i_ev_predicted),
        .i_ev_measured      (i_ev_measured),
        .i_ev_matched       (i_ev_matched),
        .i_patch_ok         (i_patch_ok),
        .i_sensor_x         (i_sensor_x),
        .i_sensor_y         (i_sensor_y),
        .i_sensor_z         (i_sensor_z),
        .i_landmark_x       (i_landmark_x),
        .i_landmark_y       (i_landmark_y),
        .i_landmark_z       (i_landmark_z),
        .o_done             (o_done),
        .o_obs_accepted     (o_obs_accepted),
        .o_view_found       (o_view_found),
        .o_view_index       (o_view_index),
        .o_prediction_valid (o_prediction_valid),
        .o_new_view_stored  (o_new_view_stored),
        .o_store_full       (o_store_full),
        .o_view_count       (o_view_count)
    );
endmodule
`default_nettype wire
